@@ hdl/ssfe_pkg.sv @@
// shared types and constants of the spi slave frame exchanger
package ssfe_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int STORE_DEPTH = 8;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 3;
    localparam int COUNT_W     = 4;
    localparam int FRAME_W     = STORE_DEPTH * BYTE_W;
    localparam int OP_W        = 2;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = BYTE_W + FRAME_W;

    typedef enum logic [OP_W-1:0] {
        OP_BYTE = 2'd0,
        OP_LOAD = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  tx_byte;
        logic               frame_ready;
        logic [FRAME_W-1:0] request_frame;
    } result_t;

endpackage

@@ hdl/ssfe_engine.sv @@
// request capture and response sequencing state with the per-item result logic
module ssfe_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [ssfe_pkg::OP_W-1:0]       operation,
    input  logic [ssfe_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                            write_collision,
    input  logic [ssfe_pkg::FRAME_W-1:0]    response_frame,
    output ssfe_pkg::result_t               result
);
    import ssfe_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(FRAME_BYTES);

    logic [BYTE_W-1:0]  req_store_reg  [STORE_DEPTH];
    logic [BYTE_W-1:0]  req_store_next [STORE_DEPTH];
    logic [BYTE_W-1:0]  rsp_store_reg  [STORE_DEPTH];
    logic [BYTE_W-1:0]  rsp_store_next [STORE_DEPTH];
    logic [COUNT_W-1:0] req_count_reg, req_count_next;
    logic [COUNT_W-1:0] rsp_pos_reg, rsp_pos_next;
    logic               capturing_reg, capturing_next;

    logic               rsp_pending;
    logic               cap_now;
    logic [COUNT_W-1:0] pos_inc;
    logic [COUNT_W-1:0] count_inc;

    assign rsp_pending = (rsp_store_reg[0] != '0) && (rsp_pos_reg < FULL_COUNT);
    assign pos_inc     = rsp_pos_reg + 1'b1;
    assign count_inc   = req_count_reg + 1'b1;
    assign cap_now     = capturing_reg || (rx_byte != '0);

    always_comb
    begin
        req_store_next = req_store_reg;
        rsp_store_next = rsp_store_reg;
        req_count_next = req_count_reg;
        rsp_pos_next   = rsp_pos_reg;
        capturing_next = capturing_reg;
        result         = '0;
        case (op_t'(operation))
            OP_BYTE:
            begin
                if (rsp_pending)
                begin
                    result.tx_byte = rsp_store_reg[rsp_pos_reg[IDX_W-1:0]];
                    if (!write_collision)
                    begin
                        rsp_pos_next = pos_inc;
                        // last response byte sent: drop marker, restart both counters
                        if (pos_inc == FULL_COUNT)
                        begin
                            rsp_pos_next      = '0;
                            req_count_next    = '0;
                            rsp_store_next[0] = '0;
                        end
                    end
                end
                else
                begin
                    capturing_next = cap_now;
                    if (cap_now && (req_count_reg < FULL_COUNT))
                    begin
                        req_store_next[req_count_reg[IDX_W-1:0]] = rx_byte;
                        req_count_next = count_inc;
                    end
                    if (req_count_next == FULL_COUNT)
                    begin
                        capturing_next = 1'b0;
                    end
                end
            end
            OP_LOAD:
            begin
                for (int i = 0; i < STORE_DEPTH; i++)
                begin
                    if (i < FRAME_BYTES)
                    begin
                        rsp_store_next[i] = response_frame[i*BYTE_W +: BYTE_W];
                    end
                end
            end
            OP_POLL:
            begin
                if ((rsp_store_reg[0] == '0) && (req_count_reg == FULL_COUNT))
                begin
                    result.frame_ready = 1'b1;
                    for (int i = 0; i < STORE_DEPTH; i++)
                    begin
                        if (i < FRAME_BYTES)
                        begin
                            result.request_frame[i*BYTE_W +: BYTE_W] = req_store_reg[i];
                        end
                    end
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                req_store_reg[i] <= '0;
                rsp_store_reg[i] <= '0;
            end
            req_count_reg <= '0;
            rsp_pos_reg   <= '0;
            capturing_reg <= 1'b0;
        end
        else if (accept)
        begin
            req_store_reg <= req_store_next;
            rsp_store_reg <= rsp_store_next;
            req_count_reg <= req_count_next;
            rsp_pos_reg   <= rsp_pos_next;
            capturing_reg <= capturing_next;
        end
    end

endmodule

@@ hdl/ssfe_out_reg.sv @@
// result register with its valid flag toward the output stream
module ssfe_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ssfe_pkg::result_t   result,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output ssfe_pkg::result_t   out_result
);
    import ssfe_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && can_load)
        begin
            data_reg <= result;
        end
    end

endmodule

@@ hdl/spi_slave_frame_exchanger_core.sv @@
// top level of the spi slave request/response frame exchanger
// Byte-level framer for an SPI slave. Each input transaction carries one operation:
// a byte exchanged on the bus (rx_byte plus the write collision flag), loading an
// 8-byte response frame, or a poll for a captured request. Every input transaction
// yields exactly one output transaction. While a response is pending (its first
// byte nonzero) each byte event returns the next response byte in tx_byte and
// advances unless a collision is flagged; after the last byte the response marker
// and both counters clear. Otherwise the block waits for a nonzero byte, captures
// the request bytes and returns 0. A poll reports the captured frame with
// frame_ready set when the request is full and no response is pending. The output
// transaction follows in the cycle after its input; the state update and the result
// are computed in one pass and land in a single result register, so a new input
// transaction is taken every cycle as long as the output side keeps draining.
module spi_slave_frame_exchanger_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // rx_byte [7:0], write_collision [8], response_frame [72:9], zero fill [79:73]
    input  logic [ssfe_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation [1:0]
    input  logic [ssfe_pkg::OP_W-1:0]          s_tuser,
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tx_byte [7:0], request_frame [71:8]
    output logic [ssfe_pkg::M_TDATA_W-1:0]     m_tdata,
    // frame_ready [0]
    output logic                               m_tuser
);
    import ssfe_pkg::*;

    logic    accept;
    result_t result;
    result_t out_result;

    // input transaction accepted whenever the result register is free or draining
    assign accept = s_tvalid && s_tready;

    ssfe_engine u_engine
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .operation       (s_tuser),
        .rx_byte         (s_tdata[BYTE_W-1:0]),
        .write_collision (s_tdata[BYTE_W]),
        .response_frame  (s_tdata[BYTE_W+1 +: FRAME_W]),
        .result          (result)
    );

    ssfe_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result     (result),
        .can_load   (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // pack the output fields, tx_byte in the lowest bits
    assign m_tdata = {out_result.request_frame, out_result.tx_byte};
    assign m_tuser = out_result.frame_ready;

endmodule

@@ hdl/ssfe_checker.sv @@
// port-level checker for the frame exchanger core, with its bind
module ssfe_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [ssfe_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               m_tuser
);
    import ssfe_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // every accepted input gives a result in the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted input produced no result");

    // empty result register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // request frame only shown with frame_ready
    a_frame_gated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[M_TDATA_W-1:BYTE_W] == '0)
        else $error("request frame without frame_ready");

    // a poll result with frame_ready set never carries a transmit byte
    a_poll_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[BYTE_W-1:0] == '0)
        else $error("tx byte set on poll result");

endmodule

bind spi_slave_frame_exchanger_core ssfe_checker u_ssfe_checker (.*);
